>>> rtl/ppta_pkg.sv
`timescale 1ns / 1ps

package ppta_pkg;

	// Fixed field widths
	localparam int FIELD_W = 16;
	localparam int ACC_W   = 40;
	localparam int AREA_W  = 38;
	localparam int LCNT_W  = 13;
	localparam logic [LCNT_W-1:0] LCNT_MAX = 13'd8191;

	// Answer kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Request op codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_FEW  = 2'd1;
	localparam logic [1:0] ST_TOO_MANY = 2'd2;
	localparam logic [1:0] ST_NO_POLY  = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EMIT,
		L_M1,
		L_M2,
		L_M3,
		L_M4,
		L_M5,
		L_ABS,
		Q_START,
		Q_PRIME,
		Q_DIFF,
		Q_MUL_L,
		Q_MUL_R,
		Q_END
	} state_t;

endpackage

>>> rtl/polygon_point_test_and_area_top.sv
`timescale 1ns / 1ps

// Polygon point-in-polygon test and area.
// Request channel (req_valid/req_stall): op = load selects one polygon vertex
// (point_x, point_y), with last marking the closing vertex; op = query asks
// whether point (point_x, point_y) lies inside by ray-crossing parity.
// Response channel (rsp_valid/rsp_stall): one response per closing load
// (status, twice the absolute area) and one per query (status, inside flag).
// A non-closing load gives no response.
// A load that adds a shoelace term, and a successful close, pass through the
// multiply states; a rejected close or a query with no polygon goes straight
// to the response, and a query walks every edge of the polygon. The response
// is handed off through an output register.
// The single shared multiplier serves all of these: each edge needs two
// products, and each shoelace term two more.
// req_stall is high while a request is being worked on. The response sits in
// an output register; while rsp_stall holds it, a finished result waits in
// the sequencer and no new request is taken.
// Reset clears the polygon (queries answer no polygon) and any load in
// progress; the vertex table itself is not cleared.
module polygon_point_test_and_area_top
	import ppta_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               op,
	input  logic [FIELD_W-1:0] point_x,
	input  logic [FIELD_W-1:0] point_y,
	input  logic               last,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               answer_kind,
	output logic [1:0]         status,
	output logic               inside_res,
	output logic [AREA_W-1:0]  double_area
);

	// Effective coordinate width: input bits above it are ignored
	localparam int CW   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
	localparam int DW   = CW + 1;          // edge differences
	localparam int PW   = 2 * DW;          // multiplier product
	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int CNTW = $clog2(MAX_VERTICES + 1);
	localparam logic [LCNT_W-1:0] MAXV = LCNT_W'(MAX_VERTICES);

	state_t state_q, state_d;

	// Control state
	logic [CNTW-1:0]   vcount_q;
	logic [LCNT_W-1:0] lcnt_q;
	logic              ovf_q;
	logic              pvalid_q;
	logic              close_q;
	logic              cmp_pend_q;
	logic [AW-1:0]     idx_q;
	logic [ACC_W-1:0]  acc_q;
	logic              out_valid_q;

	// Payload
	logic signed [CW-1:0] cx_q, cy_q;   // current vertex or query point
	logic signed [CW-1:0] lx_q, ly_q;   // previously loaded vertex
	logic signed [CW-1:0] fx_q, fy_q;   // first vertex of the load
	logic signed [CW-1:0] bx_q, by_q;   // trailing edge end in a query
	logic signed [DW-1:0] dy_q, dxp_q, dxe_q, dyp_q;
	logic                 strad_q, dypos_q;
	logic signed [PW-1:0] prod_q, lhs_q;
	logic [2*CW-1:0]      rd_q;
	logic [2*CW-1:0]      vtx_mem [MAX_VERTICES];

	logic              res_kind_q;
	logic [1:0]        res_status_q;
	logic              inside_q;
	logic [AREA_W-1:0] res_area_q;

	logic              out_kind_q;
	logic [1:0]        out_status_q;
	logic              out_inside_q;
	logic [AREA_W-1:0] out_area_q;

	// Request decode
	logic                 req_acc;
	logic signed [CW-1:0] in_x, in_y;
	logic                 k_zero, k_in, err_many, err_few, need_cross;
	logic [LCNT_W-1:0]    k_next;

	assign req_acc    = req_valid && !req_stall;
	assign in_x       = $signed(point_x[CW-1:0]);
	assign in_y       = $signed(point_y[CW-1:0]);
	assign k_zero     = (lcnt_q == '0);
	assign k_in       = (lcnt_q < MAXV);
	assign k_next     = (lcnt_q < LCNT_MAX) ? lcnt_q + 1'b1 : lcnt_q;
	assign err_many   = ovf_q || !k_in;
	assign err_few    = (lcnt_q < LCNT_W'(2));
	assign need_cross = !k_zero && k_in;

	// Last edge index of the held polygon
	logic [CNTW-1:0] nm1;
	logic [AW-1:0]   last_idx;
	assign nm1      = vcount_q - CNTW'(1);
	assign last_idx = nm1[AW-1:0];

	// Query edge: a = vertex read now, b = trailing vertex
	logic signed [CW-1:0] ax, ay;
	logic signed [DW-1:0] dy_c, dxp_c, dxe_c, dyp_c;
	logic                 strad_c, cross_c;
	assign ax      = $signed(rd_q[CW-1:0]);
	assign ay      = $signed(rd_q[2*CW-1:CW]);
	assign dy_c    = DW'(by_q) - DW'(ay);
	assign dxp_c   = DW'(cx_q) - DW'(ax);
	assign dxe_c   = DW'(bx_q) - DW'(ax);
	assign dyp_c   = DW'(cy_q) - DW'(ay);
	assign strad_c = (ay > cy_q) != (by_q > cy_q);
	assign cross_c = strad_q && (dypos_q ? (lhs_q < prod_q) : (lhs_q > prod_q));

	// Shared multiplier
	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_c;
	assign prod_c = mul_a * mul_b;

	logic [ACC_W-1:0] prod_ext;
	assign prod_ext = {{(ACC_W-PW){prod_q[PW-1]}}, prod_q};

	logic [ACC_W-1:0] mag;
	assign mag = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;

	logic can_emit;
	assign can_emit = !out_valid_q || !rsp_stall;

	// Sequencer outputs
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_ra;

	always_comb begin
		req_stall = 1'b1;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_ra    = idx_q;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				mem_we    = req_valid && (op == OP_LOAD) && k_in;
			end
			L_M1: begin
				mul_a = DW'(lx_q);
				mul_b = DW'(cy_q);
			end
			L_M2: begin
				mul_a = DW'(cx_q);
				mul_b = DW'(ly_q);
			end
			L_M3: begin
				mul_a = DW'(cx_q);
				mul_b = DW'(fy_q);
			end
			L_M4: begin
				mul_a = DW'(fx_q);
				mul_b = DW'(cy_q);
			end
			Q_START: begin
				mem_re = 1'b1;
				mem_ra = last_idx;
			end
			Q_PRIME: begin
				mem_re = 1'b1;
				mem_ra = '0;
			end
			Q_MUL_L: begin
				mul_a = dxp_q;
				mul_b = dy_q;
			end
			Q_MUL_R: begin
				mul_a  = dxe_q;
				mul_b  = dyp_q;
				mem_re = (idx_q != last_idx);
				mem_ra = idx_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (op == OP_QUERY) begin
						state_d = pvalid_q ? Q_START : S_EMIT;
					end else if (last) begin
						state_d = (err_many || err_few) ? S_EMIT : L_M1;
					end else begin
						state_d = need_cross ? L_M1 : S_IDLE;
					end
				end
			end
			S_EMIT:  state_d = can_emit ? S_IDLE : S_EMIT;
			L_M1:    state_d = L_M2;
			L_M2:    state_d = L_M3;
			L_M3:    state_d = close_q ? L_M4 : S_IDLE;
			L_M4:    state_d = L_M5;
			L_M5:    state_d = L_ABS;
			L_ABS:   state_d = S_EMIT;
			Q_START: state_d = Q_PRIME;
			Q_PRIME: state_d = Q_DIFF;
			Q_DIFF:  state_d = Q_MUL_L;
			Q_MUL_L: state_d = Q_MUL_R;
			Q_MUL_R: state_d = (idx_q == last_idx) ? Q_END : Q_DIFF;
			Q_END:   state_d = S_EMIT;
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vcount_q    <= '0;
			lcnt_q      <= '0;
			ovf_q       <= 1'b0;
			pvalid_q    <= 1'b0;
			close_q     <= 1'b0;
			cmp_pend_q  <= 1'b0;
			idx_q       <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new response may replace the one taken at this edge
			if ((state_q == S_EMIT) && can_emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && (op == OP_LOAD)) begin
						if (k_zero) begin
							acc_q <= '0;
						end
						if (last) begin
							lcnt_q   <= '0;
							ovf_q    <= 1'b0;
							pvalid_q <= !(err_many || err_few);
							close_q  <= !(err_many || err_few);
							if (!(err_many || err_few)) begin
								vcount_q <= k_next[CNTW-1:0];
							end
						end else begin
							lcnt_q  <= k_next;
							ovf_q   <= err_many;
							close_q <= 1'b0;
							if (k_zero) begin
								pvalid_q <= 1'b0;
							end
						end
					end
				end
				L_M2:  acc_q <= acc_q + prod_ext;
				L_M3:  acc_q <= acc_q - prod_ext;
				L_M4:  acc_q <= acc_q + prod_ext;
				L_M5:  acc_q <= acc_q - prod_ext;
				L_ABS: acc_q <= '0;
				Q_START: begin
					idx_q      <= '0;
					cmp_pend_q <= 1'b0;
				end
				Q_MUL_R: begin
					cmp_pend_q <= 1'b1;
					if (idx_q != last_idx) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					cx_q       <= in_x;
					cy_q       <= in_y;
					res_kind_q <= (op == OP_QUERY) ? KIND_QUERY : KIND_LOAD;
					inside_q   <= 1'b0;
					res_area_q <= '0;
					if (op == OP_QUERY) begin
						res_status_q <= pvalid_q ? ST_OK : ST_NO_POLY;
					end else begin
						if (err_many) begin
							res_status_q <= ST_TOO_MANY;
						end else if (err_few) begin
							res_status_q <= ST_TOO_FEW;
						end else begin
							res_status_q <= ST_OK;
						end
						if (k_zero) begin
							fx_q <= in_x;
							fy_q <= in_y;
							lx_q <= in_x;
							ly_q <= in_y;
						end
					end
				end
			end
			S_EMIT: begin
				if (can_emit) begin
					out_kind_q   <= res_kind_q;
					out_status_q <= res_status_q;
					out_inside_q <= inside_q;
					out_area_q   <= res_area_q;
				end
			end
			L_M3: begin
				lx_q <= cx_q;
				ly_q <= cy_q;
			end
			L_ABS: res_area_q <= mag[AREA_W-1:0];
			Q_PRIME: begin
				bx_q <= $signed(rd_q[CW-1:0]);
				by_q <= $signed(rd_q[2*CW-1:CW]);
			end
			Q_DIFF: begin
				// finish the previous edge while setting up this one
				if (cmp_pend_q && cross_c) begin
					inside_q <= !inside_q;
				end
				dy_q    <= dy_c;
				dxp_q   <= dxp_c;
				dxe_q   <= dxe_c;
				dyp_q   <= dyp_c;
				strad_q <= strad_c;
				dypos_q <= (by_q > ay);
				bx_q    <= ax;
				by_q    <= ay;
			end
			Q_MUL_R: lhs_q <= prod_q;
			Q_END: begin
				if (cross_c) begin
					inside_q <= !inside_q;
				end
			end
			default: ;
		endcase
	end

	// Vertex table: {y, x}
	always_ff @(posedge clk) begin
		if (mem_we) begin
			vtx_mem[lcnt_q[AW-1:0]] <= {in_y, in_x};
		end
		if (mem_re) begin
			rd_q <= vtx_mem[mem_ra];
		end
	end

	assign rsp_valid   = out_valid_q;
	assign answer_kind = out_kind_q;
	assign status      = out_status_q;
	assign inside_res  = out_inside_q;
	assign double_area = out_area_q;

endmodule
